>>> sv/sfp_pkg.sv
// Shared types, constants and CRC/length functions for the serial frame parser.
package sfp_pkg;

  localparam logic [7:0] SOF_BYTE = 8'hA5;
  localparam logic [5:0] MAX_FRAME_BYTES = 6'd41;
  localparam logic [15:0] CMD_NO_LINK_A = 16'h0104;
  localparam logic [15:0] CMD_NO_LINK_B = 16'h0105;

  localparam logic [15:0] TIMEOUT_RST = 16'd300;
  localparam logic [7:0] HDR_SEED_RST = 8'hFF;
  localparam logic [15:0] FRM_SEED_RST = 16'hFFFF;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_LINK_TIMEOUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HDR_SEED = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRM_SEED = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_ACCEPTED = 3'd1,
    EV_HDR_CRC_FAIL = 3'd2,
    EV_FRM_CRC_FAIL = 3'd3,
    EV_OVERRUN = 3'd4
  } sfp_event_t;

  typedef struct packed {
    logic [15:0] link_timeout_ticks;
    logic [7:0] header_crc_seed;
    logic [15:0] frame_crc_seed;
  } sfp_cfg_t;

  typedef struct packed {
    logic link_online;
    sfp_event_t frame_event;
    logic [15:0] cmd_code;
    logic [5:0] frame_bytes;
  } sfp_result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [5:0] frame_len(input logic [15:0] code);
    logic [5:0] len;
    case (code)
      16'h0001: len = 6'd12;
      16'h0002: len = 6'd10;
      16'h0003: len = 6'd41;
      16'h0004: len = 6'd12;
      16'h0101: len = 6'd13;
      16'h0102: len = 6'd13;
      16'h0103: len = 6'd11;
      16'h0104: len = 6'd11;
      16'h0105: len = 6'd10;
      16'h0201: len = 6'd27;
      16'h0202: len = 6'd25;
      16'h0203: len = 6'd25;
      16'h0204: len = 6'd10;
      16'h0205: len = 6'd12;
      16'h0206: len = 6'd10;
      16'h0207: len = 6'd15;
      16'h0208: len = 6'd11;
      16'h0209: len = 6'd13;
      16'h020A: len = 6'd21;
      16'h0301: len = 6'd25;
      default: len = 6'd0;
    endcase
    return len;
  endfunction

endpackage

>>> sv/serial_frame_parser_with_link_watch.sv
// Top level of the serial frame parser with link watch: configuration registers and wiring.
// Every input word (a received byte or a millisecond tick) yields exactly one result word.
// A word is accepted in every cycle while the two-word result queue has room, and its
// result is registered there and offered once the words ahead of it are taken; the parser
// state updates in a single pass per word. Configuration registers are written through
// cfg_we, cfg_index and cfg_data and take effect at once; the CRC seeds are picked up at
// the next start byte. No clearing pass is needed after reset.
module serial_frame_parser_with_link_watch (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic link_online,
  output logic [2:0] frame_event,
  output logic [15:0] cmd_code,
  output logic [5:0] frame_bytes,
  input  logic cfg_we,
  input  logic [sfp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import sfp_pkg::*;

  sfp_cfg_t cfg;
  sfp_result_t result;
  sfp_result_t head;
  logic not_full;
  logic in_fire;

  assign in_ready = not_full;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_timeout_ticks <= TIMEOUT_RST;
      cfg.header_crc_seed <= HDR_SEED_RST;
      cfg.frame_crc_seed <= FRM_SEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINK_TIMEOUT: cfg.link_timeout_ticks <= cfg_data;
        REG_HDR_SEED: cfg.header_crc_seed <= cfg_data[7:0];
        REG_FRM_SEED: cfg.frame_crc_seed <= cfg_data;
        default: ;
      endcase
    end
  end

  sfp_core u_core (
    .clk(clk),
    .rst(rst),
    .in_fire(in_fire),
    .req_type(req_type),
    .rx_byte(rx_byte),
    .cfg(cfg),
    .result(result)
  );

  sfp_out_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(in_fire),
    .push_data(result),
    .not_full(not_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head(head)
  );

  assign link_online = head.link_online;
  assign frame_event = head.frame_event;
  assign cmd_code = head.cmd_code;
  assign frame_bytes = head.frame_bytes;

endmodule

>>> sv/sfp_core.sv
// Frame parser and link watch state with the per-word next-state and result logic.
module sfp_core (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic req_type,
  input  logic [7:0] rx_byte,
  input  sfp_pkg::sfp_cfg_t cfg,
  output sfp_pkg::sfp_result_t result
);
  import sfp_pkg::*;

  logic in_frame, in_frame_next;
  logic [5:0] byte_count, byte_count_next;
  logic [15:0] cmd_reg, cmd_reg_next;
  logic [7:0] header_crc, header_crc_next;
  logic [15:0] frame_crc, frame_crc_next;
  logic [15:0] last_two_bytes, last_two_bytes_next;
  logic frame_seen, frame_seen_next;
  logic [15:0] silence_count, silence_count_next;
  logic online_flag, online_flag_next;

  logic [5:0] cnt;
  logic [16:0] silence_inc;
  logic drop;

  assign cnt = byte_count + 6'd1;
  assign silence_inc = {1'b0, silence_count} + 17'd1;

  always_comb begin
    in_frame_next = in_frame;
    byte_count_next = byte_count;
    cmd_reg_next = cmd_reg;
    header_crc_next = header_crc;
    frame_crc_next = frame_crc;
    last_two_bytes_next = last_two_bytes;
    frame_seen_next = frame_seen;
    silence_count_next = silence_count;
    online_flag_next = online_flag;
    drop = 1'b0;
    result.frame_event = EV_NONE;
    result.cmd_code = 16'h0000;
    result.frame_bytes = 6'd0;

    if (req_type) begin
      if (frame_seen) begin
        silence_count_next = 16'h0000;
        online_flag_next = 1'b1;
        frame_seen_next = 1'b0;
      end else begin
        if (silence_inc > {1'b0, cfg.link_timeout_ticks}) begin
          online_flag_next = 1'b0;
        end
        silence_count_next = silence_inc[16] ? 16'hFFFF : silence_inc[15:0];
      end
    end else if (!in_frame) begin
      if (rx_byte == SOF_BYTE) begin
        in_frame_next = 1'b1;
        byte_count_next = 6'd1;
        cmd_reg_next = 16'h0000;
        header_crc_next = crc8_byte(cfg.header_crc_seed, rx_byte);
        frame_crc_next = cfg.frame_crc_seed;
        last_two_bytes_next = {8'h00, rx_byte};
      end
    end else begin
      if (byte_count >= 6'd2) begin
        frame_crc_next = crc16_byte(frame_crc, last_two_bytes[15:8]);
      end
      last_two_bytes_next = {last_two_bytes[7:0], rx_byte};
      if (byte_count < 6'd4) begin
        header_crc_next = crc8_byte(header_crc, rx_byte);
      end
      byte_count_next = cnt;

      if (byte_count == 6'd4) begin
        if (header_crc != rx_byte) begin
          result.frame_event = EV_HDR_CRC_FAIL;
          drop = 1'b1;
        end
      end else if (byte_count == 6'd5) begin
        cmd_reg_next = {cmd_reg[15:8], rx_byte};
      end else if (byte_count == 6'd6) begin
        cmd_reg_next = {rx_byte, cmd_reg[7:0]};
      end

      if (!drop && cnt >= 6'd7 && frame_len(cmd_reg_next) == cnt) begin
        result.cmd_code = cmd_reg_next;
        drop = 1'b1;
        if (last_two_bytes_next[15:8] == frame_crc_next[7:0]
            && last_two_bytes_next[7:0] == frame_crc_next[15:8]) begin
          result.frame_event = EV_ACCEPTED;
          if (cmd_reg_next != CMD_NO_LINK_A && cmd_reg_next != CMD_NO_LINK_B) begin
            frame_seen_next = 1'b1;
          end
        end else begin
          result.frame_event = EV_FRM_CRC_FAIL;
        end
      end
      if (!drop && cnt >= MAX_FRAME_BYTES) begin
        result.frame_event = EV_OVERRUN;
        result.cmd_code = cmd_reg_next;
        drop = 1'b1;
      end
      if (drop) begin
        result.frame_bytes = cnt;
        in_frame_next = 1'b0;
        byte_count_next = 6'd0;
      end
    end
    result.link_online = online_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      byte_count <= 6'd0;
      cmd_reg <= 16'h0000;
      header_crc <= HDR_SEED_RST;
      frame_crc <= FRM_SEED_RST;
      last_two_bytes <= 16'h0000;
      frame_seen <= 1'b0;
      silence_count <= 16'h0000;
      online_flag <= 1'b0;
    end else if (in_fire) begin
      in_frame <= in_frame_next;
      byte_count <= byte_count_next;
      cmd_reg <= cmd_reg_next;
      header_crc <= header_crc_next;
      frame_crc <= frame_crc_next;
      last_two_bytes <= last_two_bytes_next;
      frame_seen <= frame_seen_next;
      silence_count <= silence_count_next;
      online_flag <= online_flag_next;
    end
  end

endmodule

>>> sv/sfp_out_queue.sv
// Two-word result queue that parts the input side from the output handshake.
module sfp_out_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  sfp_pkg::sfp_result_t push_data,
  output logic not_full,
  output logic out_valid,
  input  logic out_ready,
  output sfp_pkg::sfp_result_t head
);
  import sfp_pkg::*;

  sfp_result_t entries [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic pop;

  assign out_valid = count != 2'd0;
  assign not_full = count != 2'd2;
  assign pop = out_valid && out_ready;
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/sfp_checker.sv
// Port-level checker for the serial frame parser, bound to the top level.
module sfp_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] frame_event,
  input logic [15:0] cmd_code,
  input logic [5:0] frame_bytes
);
  import sfp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_event) && $stable(cmd_code))
    else $error("Result word changed or dropped while stalled.");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_event == EV_NONE |-> cmd_code == 16'h0000 && frame_bytes == 6'd0)
    else $error("Word without a frame event reports a frame.");

  a_hdr_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_event == EV_HDR_CRC_FAIL |-> cmd_code == 16'h0000 && frame_bytes == 6'd5)
    else $error("Header CRC failure not reported at byte five.");

  a_accept_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_event == EV_ACCEPTED |-> frame_bytes >= 6'd10
      && frame_bytes <= MAX_FRAME_BYTES)
    else $error("Accepted frame has a length outside the table range.");

endmodule

bind serial_frame_parser_with_link_watch sfp_checker u_sfp_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .frame_event(frame_event),
  .cmd_code(cmd_code),
  .frame_bytes(frame_bytes)
);
